>>> rtl/sbe_pkg.sv
// sbe_pkg: shared types, opcode and status codes, and helpers for the
// stack bytecode executor. No dependencies.
package sbe_pkg;

	localparam logic [7:0] OP_PUSHC   = 8'd1;
	localparam logic [7:0] OP_LOAD    = 8'd2;
	localparam logic [7:0] OP_STORE   = 8'd3;
	localparam logic [7:0] OP_POP     = 8'd4;
	localparam logic [7:0] OP_DUP     = 8'd5;
	localparam logic [7:0] IADD       = 8'd10;
	localparam logic [7:0] OP_ISUB    = 8'd11;
	localparam logic [7:0] OP_IMUL    = 8'd12;
	localparam logic [7:0] IDIV       = 8'd13;
	localparam logic [7:0] OP_IREM    = 8'd14;
	localparam logic [7:0] OP_INEG    = 8'd15;
	localparam logic [7:0] OP_IXOR    = 8'd16;
	localparam logic [7:0] OP_IAND    = 8'd17;
	localparam logic [7:0] OP_IOR     = 8'd18;
	localparam logic [7:0] LADD       = 8'd20;
	localparam logic [7:0] OP_LSUB    = 8'd21;
	localparam logic [7:0] OP_LMUL    = 8'd22;
	localparam logic [7:0] OP_LDIV    = 8'd23;
	localparam logic [7:0] OP_LREM    = 8'd24;
	localparam logic [7:0] OP_LNEG    = 8'd25;
	localparam logic [7:0] LXOR       = 8'd26;
	localparam logic [7:0] OP_RETURN  = 8'd90;

	localparam logic [1:0] MODE_POOL  = 2'd0;
	localparam logic [1:0] MODE_LOCAL = 2'd1;
	localparam logic [1:0] MODE_EXEC  = 2'd2;
	localparam logic [1:0] MODE_START = 2'd3;

	localparam logic [1:0] ST_VALUE   = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_FAULT   = 2'd3;

	typedef enum logic [3:0] {
		K_PUSHC, K_LOAD, K_STORE, K_POP, K_DUP, K_NEG,
		K_ALU, K_MUL, K_DIV, K_RET, K_BAD
	} kind_t;

	typedef struct packed {
		logic [1:0]  mode;
		kind_t       kind;
		logic        lng;
		logic [7:0]  opc;
		logic [7:0]  index;
		logic [63:0] value;
		logic        tag;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [63:0] val;
		logic        tag;
	} res_t;

	// status from the back end, watched by the top level checks
	typedef struct packed {
		logic enq;
		logic room;
		logic halted;
	} dbg_t;

	function automatic logic [63:0] sext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic kind_t decode_kind(input logic [7:0] opc);
		kind_t k;
		case (opc)
			OP_PUSHC: k = K_PUSHC;
			OP_LOAD: k = K_LOAD;
			OP_STORE: k = K_STORE;
			OP_POP: k = K_POP;
			OP_DUP: k = K_DUP;
			OP_INEG, OP_LNEG: k = K_NEG;
			IADD, OP_ISUB, OP_IXOR, OP_IAND, OP_IOR, LADD, OP_LSUB, LXOR: k = K_ALU;
			OP_IMUL, OP_LMUL: k = K_MUL;
			IDIV, OP_IREM, OP_LDIV, OP_LREM: k = K_DIV;
			OP_RETURN: k = K_RET;
			default: k = K_BAD;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/sbe_front.sv
// sbe_front: accepts input transactions, classifies them and holds them in a
// two-entry queue for the back end. Depends on sbe_pkg.
module sbe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          mode,
	input  logic [7:0]          opcode,
	input  logic [7:0]          index,
	input  logic signed [63:0]  value,
	input  logic                is_long,
	input  logic                last_word,
	output logic                item_valid,
	output sbe_pkg::item_t      item,
	input  logic                item_pop
);
	sbe_pkg::item_t ent_q [2];
	sbe_pkg::item_t dec;
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	always_comb begin
		dec.mode  = mode;
		dec.kind  = sbe_pkg::decode_kind(opcode);
		dec.lng   = (opcode >= sbe_pkg::LADD) && (opcode <= sbe_pkg::LXOR);
		dec.opc   = opcode;
		dec.index = index;
		dec.value = is_long ? value : sbe_pkg::sext32(value);
		dec.tag   = is_long;
		dec.last  = last_word;
	end

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

>>> rtl/sbe_div.sv
// sbe_div: unsigned 64-bit restoring divider, one quotient bit per cycle.
// Standalone; no package use.
module sbe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dvd,
	input  logic [63:0] dvs,
	output logic        done,
	output logic [63:0] quo,
	output logic [63:0] rem
);
	logic [6:0]  cnt_q;
	logic        run_q, done_q;
	logic [63:0] q_q, d_q;
	logic [63:0] r_q;
	logic [64:0] shf;
	logic [63:0] dif;
	logic        ge;

	assign shf = {r_q, q_q[63]};
	assign ge  = (shf >= {1'b0, d_q});
	assign dif = shf[63:0] - d_q;

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dvd;
			d_q <= dvs;
			r_q <= 64'd0;
		end else if (run_q) begin
			r_q <= ge ? dif : shf[63:0];
			q_q <= {q_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 7'd0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;
endmodule

>>> rtl/sbe_back.sv
// sbe_back: executes queued items against the stack, locals and pool
// memories and queues results. Depends on sbe_pkg and sbe_div.
module sbe_back #(
	parameter int STACK_DEPTH = 64,
	parameter int LOCAL_COUNT = 256,
	parameter int POOL_COUNT  = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  sbe_pkg::item_t      item,
	output logic                item_pop,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          status,
	output logic signed [63:0]  result_value,
	output logic                result_is_long,
	output sbe_pkg::dbg_t       dbg
);
	localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW  = $clog2(STACK_DEPTH + 1);
	localparam int LDEP = (LOCAL_COUNT > 256) ? 256 : LOCAL_COUNT;
	localparam int LAW  = (LDEP > 1) ? $clog2(LDEP) : 1;
	localparam int PDEP = (POOL_COUNT > 256) ? 256 : POOL_COUNT;
	localparam int PAW  = (PDEP > 1) ? $clog2(PDEP) : 1;

	typedef enum logic [4:0] {
		S_FETCH = 5'b00001,
		S_EXEC  = 5'b00010,
		S_MUL   = 5'b00100,
		S_DIV   = 5'b01000,
		S_WB    = 5'b10000
	} st_t;

	st_t             state_q, state_d;
	logic [SPW-1:0]  sp_q, sp_d;
	logic            halted_q;
	sbe_pkg::item_t  it_q;
	logic [LDEP-1:0] lvld_q;

	logic [64:0] stk_mem [STACK_DEPTH];
	logic [64:0] loc_mem [LDEP];
	logic [64:0] pool_mem [PDEP];
	logic [64:0] rda_s1, rdb_s1, lrd_s1, prd_s1;
	logic        lvld_s1;

	logic           stk_we, loc_we, pool_we;
	logic [SAW-1:0] stk_wa;
	logic [64:0]    stk_wd, loc_wd;
	logic [LAW-1:0] loc_wa, loc_ra;
	logic [PAW-1:0] pool_ra;
	logic           loc_set, loc_clr, start_run;

	logic        enq;
	sbe_pkg::res_t enq_d;
	sbe_pkg::res_t oq_q [2];
	logic        oq_wr_q, oq_rd_q;
	logic [1:0]  oq_cnt_q;
	logic        room;

	logic [63:0] a, b, x, y, alu_r, neg_r, fin;
	logic        pool_ok_i, loc_ok_i, sp_zero, sp_full, sp_lt2;
	logic [SAW-1:0] top_a, sec_a;

	logic [63:0] opx_q, opy_q, prod_q, acc_q, mul_a, mul_b;
	logic [1:0]  mcnt_q;
	logic        dsx_q, dsy_q, div_start, div_done;
	logic [63:0] div_quo, div_rem, wb_raw;

	assign room      = (oq_cnt_q != 2'd2);
	assign pool_ok_i = ({24'd0, it_q.index} < 32'(POOL_COUNT));
	assign loc_ok_i  = ({24'd0, it_q.index} < 32'(LOCAL_COUNT));
	assign sp_zero   = (sp_q == '0);
	assign sp_full   = (sp_q == SPW'(STACK_DEPTH));
	assign sp_lt2    = (sp_q < SPW'(2));
	assign top_a     = SAW'(sp_q - SPW'(1));
	assign sec_a     = SAW'(sp_q - SPW'(2));
	assign loc_ra    = item.index[LAW-1:0];
	assign pool_ra   = item.index[PAW-1:0];

	assign a = rda_s1[63:0];
	assign b = rdb_s1[63:0];
	assign x = it_q.lng ? b : sbe_pkg::sext32(b);
	assign y = it_q.lng ? a : sbe_pkg::sext32(a);

	always_comb begin
		case (it_q.opc)
			sbe_pkg::IADD, sbe_pkg::LADD: alu_r = x + y;
			sbe_pkg::OP_ISUB, sbe_pkg::OP_LSUB: alu_r = x - y;
			sbe_pkg::OP_IXOR, sbe_pkg::LXOR: alu_r = x ^ y;
			sbe_pkg::OP_IAND: alu_r = x & y;
			sbe_pkg::OP_IOR: alu_r = x | y;
			default: alu_r = 64'd0;
		endcase
	end
	assign neg_r = 64'd0 - a;

	// signed fixup of the divider result, or the multiply product for multiplies
	always_comb begin
		if ((it_q.opc == sbe_pkg::IDIV) || (it_q.opc == sbe_pkg::OP_LDIV)) begin
			wb_raw = (dsx_q ^ dsy_q) ? (64'd0 - div_quo) : div_quo;
		end else begin
			wb_raw = dsx_q ? (64'd0 - div_rem) : div_rem;
		end
		if (it_q.kind == sbe_pkg::K_MUL) begin
			wb_raw = acc_q;
		end
		fin = it_q.lng ? wb_raw : sbe_pkg::sext32(wb_raw);
	end

	sbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (x[63] ? (64'd0 - x) : x),
		.dvs    (y[63] ? (64'd0 - y) : y),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		item_pop  = 1'b0;
		stk_we    = 1'b0;
		stk_wa    = sp_q[SAW-1:0];
		stk_wd    = 65'd0;
		loc_we    = 1'b0;
		loc_wa    = it_q.index[LAW-1:0];
		loc_wd    = 65'd0;
		loc_set   = 1'b0;
		loc_clr   = 1'b0;
		pool_we   = 1'b0;
		start_run = 1'b0;
		div_start = 1'b0;
		enq       = 1'b0;
		enq_d     = '{st: sbe_pkg::ST_NONE, val: 64'd0, tag: 1'b0};
		case (state_q)
			S_FETCH: begin
				if (item_valid && room) begin
					item_pop = 1'b1;
					case (item.mode)
						sbe_pkg::MODE_POOL: begin
							pool_we = ({24'd0, item.index} < 32'(POOL_COUNT));
						end
						sbe_pkg::MODE_LOCAL: begin
							loc_we  = ({24'd0, item.index} < 32'(LOCAL_COUNT));
							loc_set = loc_we;
							loc_wa  = item.index[LAW-1:0];
							loc_wd  = {item.tag, item.value};
						end
						sbe_pkg::MODE_START: begin
							start_run = 1'b1;
							loc_clr   = 1'b1;
							sp_d      = '0;
						end
						default: begin
							if (!halted_q) begin
								state_d = S_EXEC;
							end
						end
					endcase
				end
			end
			S_EXEC: begin
				state_d = S_FETCH;
				case (it_q.kind)
					sbe_pkg::K_PUSHC, sbe_pkg::K_LOAD: begin
						if (sp_full || ((it_q.kind == sbe_pkg::K_PUSHC) ? !pool_ok_i : !loc_ok_i)) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							stk_we = 1'b1;
							stk_wd = (it_q.kind == sbe_pkg::K_PUSHC) ? prd_s1 :
								(lvld_s1 ? lrd_s1 : 65'd0);
							sp_d = sp_q + SPW'(1);
						end
					end
					sbe_pkg::K_STORE: begin
						if (sp_zero || !loc_ok_i) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							loc_we  = 1'b1;
							loc_set = 1'b1;
							loc_wd  = rda_s1;
							sp_d    = sp_q - SPW'(1);
						end
					end
					sbe_pkg::K_POP: begin
						if (sp_zero) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							sp_d = sp_q - SPW'(1);
						end
					end
					sbe_pkg::K_DUP: begin
						if (sp_zero || sp_full) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							stk_we = 1'b1;
							stk_wd = rda_s1;
							sp_d   = sp_q + SPW'(1);
						end
					end
					sbe_pkg::K_NEG: begin
						if (sp_zero) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							stk_we = 1'b1;
							stk_wa = top_a;
							stk_wd = {it_q.lng, it_q.lng ? neg_r : sbe_pkg::sext32(neg_r)};
						end
					end
					sbe_pkg::K_ALU: begin
						if (sp_lt2) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							stk_we = 1'b1;
							stk_wa = sec_a;
							stk_wd = {it_q.lng, it_q.lng ? alu_r : sbe_pkg::sext32(alu_r)};
							sp_d   = sp_q - SPW'(1);
						end
					end
					sbe_pkg::K_MUL: begin
						if (sp_lt2) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else begin
							state_d = S_MUL;
						end
					end
					sbe_pkg::K_DIV: begin
						if (sp_lt2) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_FAULT;
						end else if (y == 64'd0) begin
							enq = 1'b1;
							enq_d.st = sbe_pkg::ST_DIVZERO;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					sbe_pkg::K_RET: begin
						enq = 1'b1;
						if (!sp_zero) begin
							sp_d  = sp_q - SPW'(1);
							enq_d = '{st: sbe_pkg::ST_VALUE, val: a, tag: rda_s1[64]};
						end
					end
					default: begin
						enq = 1'b1;
					end
				endcase
				// end of code after an instruction that kept running
				if (!enq && (state_d == S_FETCH) && it_q.last) begin
					enq = 1'b1;
				end
			end
			S_MUL: begin
				if (mcnt_q == 2'd3) begin
					state_d = S_WB;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				state_d = S_FETCH;
				stk_we  = 1'b1;
				stk_wa  = sec_a;
				stk_wd  = {it_q.lng, fin};
				sp_d    = sp_q - SPW'(1);
				enq     = it_q.last;
			end
			default: begin
				state_d = S_FETCH;
			end
		endcase
	end

	// 64x64 low product from three 32x32 partial products
	always_comb begin
		case (mcnt_q)
			2'd1: begin
				mul_a = {32'd0, opx_q[31:0]};
				mul_b = {32'd0, opy_q[63:32]};
			end
			2'd2: begin
				mul_a = {32'd0, opx_q[63:32]};
				mul_b = {32'd0, opy_q[31:0]};
			end
			default: begin
				mul_a = {32'd0, opx_q[31:0]};
				mul_b = {32'd0, opy_q[31:0]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rda_s1  <= stk_mem[top_a];
		rdb_s1  <= stk_mem[sec_a];
		lrd_s1  <= loc_mem[loc_ra];
		lvld_s1 <= lvld_q[loc_ra];
		prd_s1  <= pool_mem[pool_ra];
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (loc_we) begin
			loc_mem[loc_wa] <= loc_wd;
		end
		if (pool_we) begin
			pool_mem[pool_ra] <= {item.tag, item.value};
		end
		if (item_pop) begin
			it_q <= item;
		end
		if (state_q == S_EXEC) begin
			opx_q <= x;
			opy_q <= y;
			dsx_q <= x[63];
			dsy_q <= y[63];
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_a * mul_b;
			case (mcnt_q)
				2'd1: acc_q <= prod_q;
				2'd2, 2'd3: acc_q <= acc_q + {prod_q[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
		if (enq) begin
			oq_q[oq_wr_q] <= enq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_FETCH;
			sp_q     <= '0;
			halted_q <= 1'b0;
			lvld_q   <= '0;
			mcnt_q   <= 2'd0;
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			if (start_run) begin
				halted_q <= 1'b0;
			end else if (enq) begin
				halted_q <= 1'b1;
			end
			if (loc_clr) begin
				lvld_q <= '0;
			end else if (loc_set) begin
				lvld_q[loc_wa] <= 1'b1;
			end
			mcnt_q <= (state_q == S_MUL) ? mcnt_q + 2'd1 : 2'd0;
			if (enq) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (pop && !empty) begin
				oq_rd_q <= ~oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, enq} - {1'b0, pop && !empty};
		end
	end

	assign empty          = (oq_cnt_q == 2'd0);
	assign status         = oq_q[oq_rd_q].st;
	assign result_value   = oq_q[oq_rd_q].val;
	assign result_is_long = oq_q[oq_rd_q].tag;
	assign dbg            = '{enq: enq, room: room, halted: halted_q};
endmodule

>>> rtl/stack_bytecode_executor_top.sv
// Setup and start transactions are handled in the back end's fetch state; other instructions
// go through execute, multiplies then the multiply state (three 32x32 partial products) and
// write-back, divides and remainders the divide state (64-step bit-serial divider) and
// write-back. A new transaction is taken only in the fetch state, when the result queue has room.
// Reset (arst_n low, asynchronous): queues empty, stack pointer 0, run not
// halted, all locals read as int 0; pool contents are kept undefined.
module stack_bytecode_executor_top #(
	parameter int STACK_DEPTH = 64,
	parameter int LOCAL_COUNT = 256,
	parameter int POOL_COUNT  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [7:0]         opcode,
	input  logic [7:0]         index,
	input  logic signed [63:0] value,
	input  logic               is_long,
	input  logic               last_word,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [63:0] result_value,
	output logic               result_is_long
);
	// front: classify each input transaction and queue it
	sbe_pkg::item_t item;
	logic           item_valid, item_pop;
	sbe_pkg::dbg_t  dbg;

	sbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.opcode     (opcode),
		.index      (index),
		.value      (value),
		.is_long    (is_long),
		.last_word  (last_word),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// back: execute against the memories, queue results for the consumer
	sbe_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.LOCAL_COUNT (LOCAL_COUNT),
		.POOL_COUNT  (POOL_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item           (item),
		.item_pop       (item_pop),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.result_value   (result_value),
		.result_is_long (result_is_long),
		.dbg            (dbg)
	);

`ifndef SYNTHESIS
	// every result halts the run
	a_halt_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		dbg.enq |=> dbg.halted)
		else $error("run not halted after a result");

	// a result is only produced when the result queue had room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		dbg.enq |-> dbg.room)
		else $error("result queue overflow");

	// non-value results carry zero payload
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status != sbe_pkg::ST_VALUE)) |-> ((result_value == 64'd0) && !result_is_long))
		else $error("non-value result carries data");
`endif
endmodule
